// ===== src/gwsc_pkg.sv =====
// shared types and constants for the grid word search counter
package gwsc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned RowW   = 9;
  localparam int unsigned TallyW = 32;
  localparam int unsigned HitsW  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] WordReset  = 32'h584D_4153;
  localparam logic [RowW-1:0]  WidthReset = 9'd256;
  localparam int unsigned      MinWidth   = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WORD_CHARS = 2'd0,
    CFG_ROW_WIDTH  = 2'd1
  } cfg_reg_e;

endpackage

// ===== src/grid_word_search_counter.sv =====
// top level: streaming eight-direction word search counter over a raster grid
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata = grid_char, tlast = grid_end
//  m_axis    out  m_axis_tvalid/tready      tdata = match_total
//  cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// one character per cycle while not stalled; the window compare and the tally update are
// combinational from the state registers into the result register
// the line store read is prefetched into a register at the next column, with write bypass
// a total is given in the cycle after the grid_end transfer; input stalls only while that
// total waits and m_axis_tready is low
// reset clears tally, position, window; sets config defaults; line store needs no clearing
module grid_word_search_counter
  import gwsc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,   // [7:0] grid_char
  input  logic                s_axis_tlast,   // grid_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TallyW-1:0]   m_axis_tdata,   // [31:0] match_total
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [WordW-1:0]    cfg_data_i
);

  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WideW = ($clog2(MAX_WIDTH + 1) > RowW) ?
                                  $clog2(MAX_WIDTH + 1) : RowW;
  localparam int unsigned LineW = 3 * CharW;

  logic [WordW-1:0]  word_q;
  logic [RowW-1:0]   width_q;
  logic [ColW-1:0]   col_q, col_d;
  logic [1:0]        rows_q, rows_d;
  logic [TallyW-1:0] tally_q, tally_d;
  logic [WordW-1:0]  win_q [3];
  logic [TallyW-1:0] out_data_q;
  logic              out_valid_q;

  logic [LineW-1:0]  line_mem [MAX_WIDTH];
  logic [LineW-1:0]  line_rd_q;
  logic [ColW-1:0]   rd_addr;

  logic              in_acc;
  logic [WordW-1:0]  cur_col;
  logic [WideW-1:0]  eff_width, width_ext, col_next;
  logic [HitsW-1:0]  hits;
  logic [TallyW:0]   tally_sum;
  logic [TallyW-1:0] tally_sat;
  logic              col_ok, row_ok, wrap;

  // 0..2 hits: segment read forward and reversed
  function automatic logic [1:0] seg_hits(input logic [WordW-1:0] s,
                                          input logic [WordW-1:0] w);
    logic [WordW-1:0] r;
    r = {s[7:0], s[15:8], s[23:16], s[31:24]};
    seg_hits = {1'b0, s == w} + {1'b0, r == w};
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign cur_col = {line_rd_q, s_axis_tdata};
  assign col_ok  = col_q >= ColW'(3);
  assign row_ok  = rows_q == 2'd3;

  always_comb begin
    logic [WordW-1:0] seg_h, seg_v, seg_d, seg_a;
    seg_h = {win_q[2][7:0], win_q[1][7:0], win_q[0][7:0], cur_col[7:0]};
    seg_v = cur_col;
    seg_d = {win_q[2][31:24], win_q[1][23:16], win_q[0][15:8], cur_col[7:0]};
    seg_a = {cur_col[31:24], win_q[0][23:16], win_q[1][15:8], win_q[2][7:0]};
    hits = '0;
    if (col_ok) hits = hits + HitsW'(seg_hits(seg_h, word_q));
    if (row_ok) hits = hits + HitsW'(seg_hits(seg_v, word_q));
    if (col_ok && row_ok) begin
      hits = hits + HitsW'(seg_hits(seg_d, word_q)) + HitsW'(seg_hits(seg_a, word_q));
    end
  end

  assign tally_sum = {1'b0, tally_q} + (TallyW + 1)'(hits);
  assign tally_sat = tally_sum[TallyW] ? '1 : tally_sum[TallyW-1:0];

  // width clamped to the supported range
  always_comb begin
    width_ext = WideW'(width_q);
    if (width_ext < WideW'(MinWidth)) begin
      eff_width = WideW'(MinWidth);
    end else if (width_ext > WideW'(MAX_WIDTH)) begin
      eff_width = WideW'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
  end

  assign col_next = WideW'(col_q) + WideW'(1);
  assign wrap     = col_next >= eff_width;

  always_comb begin
    col_d   = col_q;
    rows_d  = rows_q;
    tally_d = tally_q;
    if (in_acc) begin
      tally_d = tally_sat;
      if (wrap) begin
        col_d = '0;
        if (rows_q != 2'd3) rows_d = rows_q + 2'd1;
      end else begin
        col_d = col_next[ColW-1:0];
      end
      if (s_axis_tlast) begin
        tally_d = '0;
        col_d   = '0;
        rows_d  = '0;
      end
    end
  end

  assign rd_addr = col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= WordReset;
      width_q     <= WidthReset;
      col_q       <= '0;
      rows_q      <= '0;
      tally_q     <= '0;
      win_q[0]    <= '0;
      win_q[1]    <= '0;
      win_q[2]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_WORD_CHARS: word_q  <= cfg_data_i;
          CFG_ROW_WIDTH:  width_q <= cfg_data_i[RowW-1:0];
          default: ;
        endcase
      end
      col_q   <= col_d;
      rows_q  <= rows_d;
      tally_q <= tally_d;
      if (in_acc) begin
        if (s_axis_tlast) begin
          win_q[0] <= '0;
          win_q[1] <= '0;
          win_q[2] <= '0;
        end else begin
          win_q[0] <= cur_col;
          win_q[1] <= win_q[0];
          win_q[2] <= win_q[1];
        end
      end
      if (in_acc && s_axis_tlast) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) out_data_q <= tally_sat;
  end

  // line store: written at the current column, read ahead at the next one
  always_ff @(posedge clk_i) begin
    if (in_acc) line_mem[col_q] <= cur_col[LineW-1:0];
    if (in_acc && (rd_addr == col_q)) begin
      line_rd_q <= cur_col[LineW-1:0];
    end else begin
      line_rd_q <= line_mem[rd_addr];
    end
  end

  a_total_follows_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast |=> m_axis_tvalid)
    else $error("no total after grid end transfer");

  a_restart_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast |=> (tally_q == '0) && (col_q == '0) && (rows_q == 2'd0))
    else $error("grid position not cleared after grid end");

  a_rows_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tlast |=> rows_q >= $past(rows_q))
    else $error("rows seen went backward within a grid");

  a_tally_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tlast |=> tally_q >= $past(tally_q))
    else $error("tally dropped within a grid");

endmodule
